@@ rtl/core/qrs_pkg.sv @@
// qrs_pkg: shared payload types and root status codes for the quadratic solver.
// No dependencies; imported by quadratic_root_solver.
package qrs_pkg;

    localparam int DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        KIND_ERR  = 2'd0,
        KIND_TWO  = 2'd1,
        KIND_ONE  = 2'd2,
        KIND_CPLX = 2'd3
    } root_kind_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] coef_quad;
        logic signed [DATA_WIDTH-1:0] coef_lin;
        logic signed [DATA_WIDTH-1:0] coef_const;
    } coef_item_t;

    typedef struct packed {
        root_kind_t                   root_kind;
        logic signed [DATA_WIDTH-1:0] first_value;
        logic signed [DATA_WIDTH-1:0] second_value;
        logic                         saturated;
    } root_item_t;

endpackage

@@ rtl/core/quadratic_root_solver.sv @@
// Quadratic root solver: a fully pipelined (a, b, c) -> roots datapath.
// Root values are signed Q16.16 fixed point at the default FRAC_BITS.
// Throughput: one item per cycle while the output is not stalled; the sqrt takes one result bit per stage and
// each of the two dividers one quotient bit per stage.
// The whole pipe advances together whenever the output register is free or taken.
// Reset (aresetn, synchronous, active low) clears only the stage valid bits.
module quadratic_root_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  qrs_pkg::coef_item_t s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output qrs_pkg::root_item_t m_item
);
    import qrs_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int NW  = 2 * W + 2;      // discriminant width
    localparam int SQ  = NW / 2;         // sqrt stages, one root bit each
    localparam int RW  = W + 3;          // sqrt remainder width
    localparam int NM  = W + 2;          // numerator magnitude width
    localparam int NQ  = NM + FRAC_BITS; // quotient bits, one per divider stage
    localparam int TOT = 5 + SQ + NQ;

    typedef struct packed {
        logic         azero;
        logic         an;
        logic [W-1:0] am;
        logic         bn;
        logic [W-1:0] bm;
        root_kind_t   kind;
    } side_t;

    typedef struct packed {
        side_t         side;
        logic [RW-1:0] rem;
        logic [W:0]    root;
        logic [NW-1:0] dsh;
    } sq_t;

    typedef struct packed {
        logic [W:0]    rem;
        logic [NQ-1:0] q;
        logic [NQ-1:0] nsh;
        logic          neg;
    } lane_t;

    typedef struct packed {
        side_t side;
        lane_t l1;
        lane_t l2;
    } dv_t;

    typedef struct packed {
        logic          neg;
        logic [NM-1:0] mag;
    } sm_t;

    function automatic sm_t s_add(sm_t x, sm_t y);
        sm_t r;
        if (x.neg == y.neg) begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end else if (x.mag >= y.mag) begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end else begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        if (r.mag == '0) begin
            r.neg = 1'b0;
        end
        return r;
    endfunction

    function automatic lane_t div_step(lane_t x, logic [W-1:0] am);
        lane_t        r;
        logic [W+1:0] cur;
        logic [W+1:0] den;
        cur = {x.rem, x.nsh[NQ-1]};
        den = {1'b0, am, 1'b0};
        r   = x;
        if (cur >= den) begin
            r.rem = (W+1)'(cur - den);
            r.q   = {x.q[NQ-2:0], 1'b1};
        end else begin
            r.rem = cur[W:0];
            r.q   = {x.q[NQ-2:0], 1'b0};
        end
        r.nsh = x.nsh << 1;
        return r;
    endfunction

    function automatic lane_t div_init(sm_t n, logic an);
        lane_t r;
        r.rem = '0;
        r.q   = '0;
        r.nsh = NQ'(n.mag) << FRAC_BITS;
        r.neg = n.neg != an;
        return r;
    endfunction

    function automatic logic [W:0] finish(lane_t x);
        logic [NQ-1:0] lim;
        logic [W-1:0]  v;
        logic          sat;
        lim = x.neg ? (NQ'(1) << (W - 1)) : ((NQ'(1) << (W - 1)) - NQ'(1));
        sat = 1'b0;
        if (x.q > lim) begin
            v   = lim[W-1:0];
            sat = 1'b1;
        end else begin
            v = x.q[W-1:0];
        end
        if (x.neg) begin
            v = W'(-v);
        end
        if (x.q == '0) begin
            v = '0;
        end
        return {sat, v};
    endfunction

    logic             adv;
    logic [TOT-1:0]   vld_reg;
    coef_item_t       in_reg;
    side_t            pr_side_reg;
    logic [2*W-1:0]   pp_reg;
    logic [2*W-1:0]   ac_reg;
    sq_t              sq_reg [0:SQ];
    dv_t              dv_reg [0:NQ];
    root_item_t       out_reg;

    assign adv     = m_ready || !m_valid;
    assign s_ready = adv;
    assign m_valid = vld_reg[TOT-1];
    assign m_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[TOT-2:0], s_valid};
        end
    end

    // split into sign/magnitude and form b^2 and a*c
    logic [W-1:0] am_c, bm_c, cm_c;
    assign am_c = in_reg.coef_quad[W-1]  ? W'(-in_reg.coef_quad)  : in_reg.coef_quad;
    assign bm_c = in_reg.coef_lin[W-1]   ? W'(-in_reg.coef_lin)   : in_reg.coef_lin;
    assign cm_c = in_reg.coef_const[W-1] ? W'(-in_reg.coef_const) : in_reg.coef_const;

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg            <= s_item;
            pr_side_reg.azero <= am_c == '0;
            pr_side_reg.an    <= in_reg.coef_quad[W-1];
            pr_side_reg.am    <= am_c;
            pr_side_reg.bn    <= in_reg.coef_quad[W-1] ^ in_reg.coef_const[W-1];
            pr_side_reg.bm    <= bm_c;
            pr_side_reg.kind  <= in_reg.coef_lin[W-1] ? KIND_TWO : KIND_ONE;
            pp_reg            <= bm_c * bm_c;
            ac_reg            <= am_c * cm_c;
        end
    end

    // discriminant; the side slot carries sign(b) in kind and sign(a)^sign(c) in bn
    logic [NW-1:0] p_w, t_w, d_c;
    root_kind_t    kind_c;
    side_t         side_c;
    always_comb begin
        p_w    = NW'(pp_reg);
        t_w    = NW'(ac_reg) << 2;
        side_c = pr_side_reg;
        side_c.bn = pr_side_reg.kind == KIND_TWO;
        if (pr_side_reg.bn && t_w != '0) begin
            d_c    = p_w + t_w;
            kind_c = KIND_TWO;
        end else if (p_w > t_w) begin
            d_c    = p_w - t_w;
            kind_c = KIND_TWO;
        end else if (p_w == t_w) begin
            d_c    = '0;
            kind_c = KIND_ONE;
        end else begin
            d_c    = t_w - p_w;
            kind_c = KIND_CPLX;
        end
        side_c.kind = pr_side_reg.azero ? KIND_ERR : kind_c;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg[0].side <= side_c;
            sq_reg[0].rem  <= '0;
            sq_reg[0].root <= '0;
            sq_reg[0].dsh  <= d_c;
        end
    end

    // floored square root, one result bit per stage
    for (genvar j = 0; j < SQ; j++) begin : g_sqrt
        logic [RW+1:0] cur, trial;
        sq_t           nxt;
        always_comb begin
            cur   = {sq_reg[j].rem, sq_reg[j].dsh[NW-1:NW-2]};
            trial = (RW+2)'({sq_reg[j].root, 2'b01});
            nxt   = sq_reg[j];
            nxt.dsh = sq_reg[j].dsh << 2;
            if (cur >= trial) begin
                nxt.rem  = RW'(cur - trial);
                nxt.root = {sq_reg[j].root[W-1:0], 1'b1};
            end else begin
                nxt.rem  = cur[RW-1:0];
                nxt.root = {sq_reg[j].root[W-1:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_reg[j+1] <= nxt;
            end
        end
    end

    // numerators -b + r and -b - r, or -b and r for complex roots, else -b for both
    sm_t negb, rp, rn, num1, num2;
    always_comb begin
        negb.neg = (sq_reg[SQ].side.bm != '0) && !sq_reg[SQ].side.bn;
        negb.mag = NM'(sq_reg[SQ].side.bm);
        rp.neg   = 1'b0;
        rp.mag   = NM'(sq_reg[SQ].root);
        rn.neg   = sq_reg[SQ].root != '0;
        rn.mag   = rp.mag;
        case (sq_reg[SQ].side.kind)
            KIND_TWO: begin
                num1 = s_add(negb, rp);
                num2 = s_add(negb, rn);
            end
            KIND_CPLX: begin
                num1 = negb;
                num2 = rp;
            end
            default: begin
                num1 = negb;
                num2 = negb;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg[0].side <= sq_reg[SQ].side;
            dv_reg[0].l1   <= div_init(num1, sq_reg[SQ].side.an);
            dv_reg[0].l2   <= div_init(num2, sq_reg[SQ].side.an);
        end
    end

    // two restoring dividers by 2|a|, one quotient bit per stage
    for (genvar j = 0; j < NQ; j++) begin : g_div
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[j+1].side <= dv_reg[j].side;
                dv_reg[j+1].l1   <= div_step(dv_reg[j].l1, dv_reg[j].side.am);
                dv_reg[j+1].l2   <= div_step(dv_reg[j].l2, dv_reg[j].side.am);
            end
        end
    end

    logic [W:0] f1, f2;
    assign f1 = finish(dv_reg[NQ].l1);
    assign f2 = finish(dv_reg[NQ].l2);

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.root_kind <= dv_reg[NQ].side.kind;
            if (dv_reg[NQ].side.azero) begin
                out_reg.first_value  <= '0;
                out_reg.second_value <= '0;
                out_reg.saturated    <= 1'b0;
            end else begin
                out_reg.first_value  <= f1[W-1:0];
                out_reg.second_value <= f2[W-1:0];
                out_reg.saturated    <= f1[W] | f2[W];
            end
        end
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.root_kind == KIND_ERR |->
            m_item.first_value == '0 && m_item.second_value == '0 && !m_item.saturated)
        else $error("error result carries nonzero values");
    a_one_same: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.root_kind == KIND_ONE |-> m_item.first_value == m_item.second_value)
        else $error("repeated root values differ");
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted item not captured in first stage");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
